// ----- design/rmq_pkg.sv -----
// Shared widths, path codes and the front-end word for the
// rotation matrix to quaternion pipeline. No dependencies.
package rmq_pkg;

	// data format
	localparam int DW = 16;
	localparam int FB = 14;

	// radicand: signed sum of one and three elements, then its clamped magnitude
	localparam int RAD_W = ((DW > FB + 1) ? DW : FB + 1) + 2;
	localparam int RADM_W = RAD_W - 1;

	// square root operand (radicand scaled by the fraction) and result
	localparam int SQ_XR_W = RADM_W + FB;
	localparam int SQ_R_W = (SQ_XR_W + 1) / 2;
	localparam int SQ_X_W = 2 * SQ_R_W;
	localparam int SQ_REM_W = SQ_R_W + 3;

	// divider: numerator, dividend, divisor, partial remainder, quotient
	localparam int NUM_W = DW + 1;
	localparam int DV_W = NUM_W + FB + 1;
	localparam int DS_W = SQ_R_W + 1;
	localparam int DR_W = DS_W + 1;
	localparam int Q_W = DW;

	localparam int NLANE = 4;

	// which quaternion part comes straight from the root
	typedef enum logic [1:0] {
		SEL_W,
		SEL_X,
		SEL_Y,
		SEL_Z
	} sel_t;

	// word leaving the front end
	typedef struct packed {
		sel_t                            sel;
		logic [RADM_W-1:0]               rad;
		logic [NLANE-1:0][NUM_W-1:0]     num;
	} front_t;

endpackage

// ----- design/rmq_front.sv -----
// Front end: trace, path choice, clamped radicand and the four numerators.
// Depends on rmq_pkg.
module rmq_front (
	input  logic signed [rmq_pkg::DW-1:0] m00,
	input  logic signed [rmq_pkg::DW-1:0] m01,
	input  logic signed [rmq_pkg::DW-1:0] m02,
	input  logic signed [rmq_pkg::DW-1:0] m10,
	input  logic signed [rmq_pkg::DW-1:0] m11,
	input  logic signed [rmq_pkg::DW-1:0] m12,
	input  logic signed [rmq_pkg::DW-1:0] m20,
	input  logic signed [rmq_pkg::DW-1:0] m21,
	input  logic signed [rmq_pkg::DW-1:0] m22,
	output rmq_pkg::front_t               fr
);
	import rmq_pkg::*;

	logic signed [RAD_W-1:0] a00, a11, a22, one, trace, rad;
	logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

	assign a00 = RAD_W'(m00);
	assign a11 = RAD_W'(m11);
	assign a22 = RAD_W'(m22);
	assign one = RAD_W'(1) <<< FB;
	assign trace = a00 + a11 + a22;

	// pairwise sums and differences of off-diagonal elements
	assign d21_12 = NUM_W'(m21) - NUM_W'(m12);
	assign d02_20 = NUM_W'(m02) - NUM_W'(m20);
	assign d10_01 = NUM_W'(m10) - NUM_W'(m01);
	assign s01_10 = NUM_W'(m01) + NUM_W'(m10);
	assign s02_20 = NUM_W'(m02) + NUM_W'(m20);
	assign s12_21 = NUM_W'(m12) + NUM_W'(m21);

	// path choice; ties fall through to the later path
	always_comb begin
		fr.num = '0;
		priority if (trace > 0) begin
			fr.sel = SEL_W;
			rad = one + trace;
			fr.num[1] = d21_12;
			fr.num[2] = d02_20;
			fr.num[3] = d10_01;
		end else if (a00 > a11 && a00 > a22) begin
			fr.sel = SEL_X;
			rad = one + a00 - a11 - a22;
			fr.num[0] = d21_12;
			fr.num[2] = s01_10;
			fr.num[3] = s02_20;
		end else if (a11 > a22) begin
			fr.sel = SEL_Y;
			rad = one + a11 - a00 - a22;
			fr.num[0] = d02_20;
			fr.num[1] = s01_10;
			fr.num[3] = s12_21;
		end else begin
			fr.sel = SEL_Z;
			rad = one + a22 - a00 - a11;
			fr.num[0] = d10_01;
			fr.num[1] = s02_20;
			fr.num[2] = s12_21;
		end
		// negative radicand clamps to zero
		fr.rad = rad[RAD_W-1] ? '0 : rad[RADM_W-1:0];
	end

endmodule

// ----- design/rotation_matrix_to_quaternion_top.sv -----
// Stages: front-end register, 16 root stages (one result bit each),
// divider setup, 16 divider stages (one quotient bit each), output stage.
// One word per cycle unless a valid output word is stalled; all stages move
// together, and such a stall stalls the matrix side in the same cycle.
// Reset (arst_n low, asynchronous) clears the valid bits; data is not reset.
// Depends on rmq_pkg and rmq_front.
module rotation_matrix_to_quaternion_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mat_valid,
	output logic                          mat_stall,
	input  logic signed [rmq_pkg::DW-1:0] m00,
	input  logic signed [rmq_pkg::DW-1:0] m01,
	input  logic signed [rmq_pkg::DW-1:0] m02,
	input  logic signed [rmq_pkg::DW-1:0] m10,
	input  logic signed [rmq_pkg::DW-1:0] m11,
	input  logic signed [rmq_pkg::DW-1:0] m12,
	input  logic signed [rmq_pkg::DW-1:0] m20,
	input  logic signed [rmq_pkg::DW-1:0] m21,
	input  logic signed [rmq_pkg::DW-1:0] m22,
	output logic                          quat_valid,
	input  logic                          quat_stall,
	output logic signed [rmq_pkg::DW-1:0] quat_w,
	output logic signed [rmq_pkg::DW-1:0] quat_x,
	output logic signed [rmq_pkg::DW-1:0] quat_y,
	output logic signed [rmq_pkg::DW-1:0] quat_z,
	output logic                          degenerate
);
	import rmq_pkg::*;

	// root pipeline word
	typedef struct packed {
		sel_t                        sel;
		logic [SQ_X_W-1:0]           x;
		logic [SQ_REM_W-1:0]         rem;
		logic [SQ_R_W-1:0]           root;
		logic [NLANE-1:0][NUM_W-1:0] num;
	} sq_t;

	// divider pipeline word
	typedef struct packed {
		sel_t                       sel;
		logic [SQ_R_W-1:0]          r;
		logic [NLANE-1:0][DR_W-1:0] rem;
		logic [NLANE-1:0][Q_W-1:0]  lo;
		logic [NLANE-1:0][Q_W-1:0]  q;
		logic [NLANE-1:0]           neg;
		logic [NLANE-1:0]           ovf;
	} dv_t;

	localparam logic [Q_W-1:0] QMAX_POS = Q_W'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic [Q_W-1:0] QMAX_NEG = Q_W'(64'd1 << (DW - 1));
	localparam logic [DW-1:0] SMAX = DW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic [DW-1:0] SMIN = DW'(64'd1 << (DW - 1));

	logic adv;
	front_t fr;

	// index 0 is the front-end register, index k+1 follows root step k
	sq_t  sq_s [0:SQ_R_W];
	logic sq_vld_s [0:SQ_R_W];
	// index 0 is the divider setup register, index k+1 follows quotient step k
	dv_t  dv_s [0:Q_W];
	logic dv_vld_s [0:Q_W];

	logic [NLANE-1:0][DW-1:0] quat_q;
	logic                     degen_q;
	logic                     vld_q;

	// whole pipe moves unless a finished word is held at the output
	assign adv = !(vld_q && quat_stall);
	assign mat_stall = !adv;

	rmq_front u_front (
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.fr (fr)
	);

	// front-end register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (adv) begin
			sq_vld_s[0] <= mat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].sel <= fr.sel;
			sq_s[0].x <= SQ_X_W'({fr.rad, {FB{1'b0}}});
			sq_s[0].rem <= '0;
			sq_s[0].root <= '0;
			sq_s[0].num <= fr.num;
		end
	end

	// root: one result bit per stage, two operand bits consumed each time
	for (genvar k = 0; k < SQ_R_W; k++) begin : g_sqrt
		logic [SQ_REM_W-1:0] rem_sh, trial;
		sq_t nxt;

		always_comb begin
			nxt = sq_s[k];
			rem_sh = {sq_s[k].rem[SQ_REM_W-3:0], sq_s[k].x[SQ_X_W-1 -: 2]};
			trial = SQ_REM_W'({sq_s[k].root, 2'b01});
			nxt.x = sq_s[k].x << 2;
			if (rem_sh >= trial) begin
				nxt.rem = rem_sh - trial;
				nxt.root = {sq_s[k].root[SQ_R_W-2:0], 1'b1};
			end else begin
				nxt.rem = rem_sh;
				nxt.root = {sq_s[k].root[SQ_R_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// divider setup: magnitude, rounded dividend, divisor 2r, overflow test
	dv_t dv_init;
	logic [SQ_R_W-1:0] r_fin;
	logic [DS_W-1:0] dsor;

	assign r_fin = sq_s[SQ_R_W].root;
	assign dsor = {r_fin, 1'b0};

	always_comb begin
		logic signed [NUM_W-1:0] n;
		logic [NUM_W-1:0] mag;
		logic [DV_W-1:0] dvd;
		dv_init.sel = sq_s[SQ_R_W].sel;
		dv_init.r = r_fin;
		for (int i = 0; i < NLANE; i++) begin
			n = sq_s[SQ_R_W].num[i];
			mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
			dvd = DV_W'({mag, {FB{1'b0}}}) + DV_W'(r_fin);
			dv_init.neg[i] = n[NUM_W-1];
			dv_init.ovf[i] = (dvd[DV_W-1:Q_W] >= dsor);
			dv_init.rem[i] = DR_W'(dvd[DV_W-1:Q_W]);
			dv_init.lo[i] = dvd[Q_W-1:0];
			dv_init.q[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= sq_vld_s[SQ_R_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= dv_init;
		end
	end

	// restoring division, one quotient bit per stage in every lane
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		dv_t nxt;

		always_comb begin
			logic [DR_W-1:0] rem_sh, d;
			nxt = dv_s[k];
			d = DR_W'({dv_s[k].r, 1'b0});
			for (int i = 0; i < NLANE; i++) begin
				rem_sh = {dv_s[k].rem[i][DR_W-2:0], dv_s[k].lo[i][Q_W-1]};
				nxt.lo[i] = dv_s[k].lo[i] << 1;
				if (rem_sh >= d) begin
					nxt.rem[i] = rem_sh - d;
					nxt.q[i] = {dv_s[k].q[i][Q_W-2:0], 1'b1};
				end else begin
					nxt.rem[i] = rem_sh;
					nxt.q[i] = {dv_s[k].q[i][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// output stage: root part, signed saturation, degenerate forcing
	logic [NLANE-1:0][DW-1:0] quat_d;
	logic degen_d;
	dv_t fin;

	assign fin = dv_s[Q_W];
	assign degen_d = (fin.r == '0);

	always_comb begin
		logic [SQ_R_W:0] half;
		half = (SQ_R_W + 1)'({1'b0, fin.r} + 1'b1) >> 1;
		for (int i = 0; i < NLANE; i++) begin
			if (degen_d) begin
				quat_d[i] = '0;
			end else if (fin.sel == sel_t'(i)) begin
				quat_d[i] = (half > (SQ_R_W + 1)'(SMAX)) ? SMAX : DW'(half);
			end else if (fin.neg[i]) begin
				quat_d[i] = (fin.ovf[i] || fin.q[i] > QMAX_NEG) ? SMIN : DW'(-fin.q[i]);
			end else begin
				quat_d[i] = (fin.ovf[i] || fin.q[i] > QMAX_POS) ? SMAX : DW'(fin.q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= dv_vld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_q <= quat_d;
			degen_q <= degen_d;
		end
	end

	assign quat_valid = vld_q;
	assign quat_w = quat_q[0];
	assign quat_x = quat_q[1];
	assign quat_y = quat_q[2];
	assign quat_z = quat_q[3];
	assign degenerate = degen_q;

endmodule

// ----- design/rmq_checker.sv -----
// Port-level checks for the rotation matrix to quaternion block, and
// the bind that attaches them. Depends on rmq_pkg and the top level.
module rmq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          mat_stall,
	input logic                          quat_valid,
	input logic                          quat_stall,
	input logic signed [rmq_pkg::DW-1:0] quat_w,
	input logic signed [rmq_pkg::DW-1:0] quat_x,
	input logic signed [rmq_pkg::DW-1:0] quat_y,
	input logic signed [rmq_pkg::DW-1:0] quat_z,
	input logic                          degenerate
);
	import rmq_pkg::*;

	// a held output word does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat_stall |=> quat_valid && $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z) && $stable(degenerate))
		else $error("held quaternion word changed");

	// the matrix side stalls only behind a held output word
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall |-> quat_valid && quat_stall)
		else $error("matrix side stalled without output back-pressure");

	// degenerate words carry all-zero parts
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && degenerate |-> quat_w == '0 && quat_x == '0
			&& quat_y == '0 && quat_z == '0)
		else $error("degenerate word with nonzero parts");

	// a nonzero root always gives a nonzero selected part
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !degenerate |-> quat_w != '0 || quat_x != '0
			|| quat_y != '0 || quat_z != '0)
		else $error("regular word with all-zero parts");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);

// ----- bench/rotation_matrix_to_quaternion_top_tb.sv -----
// Testbench for rotation_matrix_to_quaternion_top: directed matrix table, then random
// rotation-like and raw matrices, checked against an in-bench quaternion predictor.
// Depends on rmq_pkg and the design files.
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_top_tb;
	import rmq_pkg::*;

	localparam int LAT = 35;
	localparam int N_RAND = 1500;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic signed [DW-1:0] ONE = 16'sd16384;
	localparam logic signed [DW-1:0] SMAXV = 16'sh7fff;
	localparam logic signed [DW-1:0] SMINV = 16'sh8000;

	typedef logic signed [DW-1:0] elem_t;

	typedef struct {
		elem_t w, x, y, z;
		logic  degen;
	} quat_t;

	typedef struct {
		elem_t m [9];
		logic  known;
		quat_t q;
	} mat_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic quat_stall = 1'b0;
	elem_t mi [9];
	logic mat_stall, quat_valid, degenerate;
	elem_t quat_w, quat_x, quat_y, quat_z;

	quat_t quat_expected [$];
	int errors = 0;
	int n_sent = 0, n_recv = 0, n_degen = 0;
	longint cycles = 0;
	int mode = 0;
	logic hold_long = 1'b0;

	initial begin
		foreach (mi[i]) mi[i] = '0;
	end

	rotation_matrix_to_quaternion_top u_top (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall),
		.m00(mi[0]), .m01(mi[1]), .m02(mi[2]),
		.m10(mi[3]), .m11(mi[4]), .m12(mi[5]),
		.m20(mi[6]), .m21(mi[7]), .m22(mi[8]),
		.quat_valid(quat_valid), .quat_stall(quat_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.degenerate(degenerate)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// saturate to the data range
	function automatic elem_t clip(longint v);
		if (v > longint'(SMAXV)) return SMAXV;
		if (v < longint'(SMINV)) return SMINV;
		return elem_t'(v);
	endfunction

	// floor square root, bit by bit
	function automatic longint floor_root(longint x);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > x) b = b >>> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >>> 1) + b;
			end else
				res = res >>> 1;
			b = b >>> 2;
		end
		return res;
	endfunction

	// n / (2r), rounded on magnitude, ties away from zero
	function automatic elem_t off_part(longint n, longint r);
		longint mag, q;
		mag = (n < 0) ? -n : n;
		q = ((mag << FB) + r) / (r << 1);
		return clip((n < 0) ? -q : q);
	endfunction

	function automatic quat_t predict_quat(elem_t m [9]);
		longint a [9];
		longint trace, rad, r;
		longint num [4];
		longint d;
		sel_t sel;
		elem_t p [4];
		quat_t q;
		foreach (m[i]) a[i] = longint'(m[i]);
		trace = a[0] + a[4] + a[8];
		num[0] = 0; num[1] = 0; num[2] = 0; num[3] = 0;
		if (trace > 0) begin
			sel = SEL_W;
			rad = longint'(ONE) + trace;
			num[1] = a[7] - a[5]; num[2] = a[2] - a[6]; num[3] = a[3] - a[1];
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			sel = SEL_X;
			rad = longint'(ONE) + a[0] - a[4] - a[8];
			num[0] = a[7] - a[5]; num[2] = a[1] + a[3]; num[3] = a[2] + a[6];
		end else if (a[4] > a[8]) begin
			sel = SEL_Y;
			rad = longint'(ONE) + a[4] - a[0] - a[8];
			num[0] = a[2] - a[6]; num[1] = a[1] + a[3]; num[3] = a[5] + a[7];
		end else begin
			sel = SEL_Z;
			rad = longint'(ONE) + a[8] - a[0] - a[4];
			num[0] = a[3] - a[1]; num[1] = a[2] + a[6]; num[2] = a[5] + a[7];
		end
		if (rad < 0) rad = 0;
		r = floor_root(rad << FB);
		q.degen = (r == 0);
		for (int i = 0; i < 4; i++) begin
			if (r == 0)
				p[i] = '0;
			else if (i == int'(sel)) begin
				d = (r + 1) >>> 1;
				p[i] = (d > longint'(SMAXV)) ? SMAXV : elem_t'(d);
			end else
				p[i] = off_part(num[i], r);
		end
		q.w = p[0]; q.x = p[1]; q.y = p[2]; q.z = p[3];
		return q;
	endfunction

	// matrix sender: waits for acceptance, sender idling per mode
	task automatic send_matrix(elem_t m [9]);
		while (mode inside {1, 3} && ($urandom_range(99) < ((mode == 1) ? 82 : 17))) begin
			mat_valid <= 1'b0;
			@(posedge clk);
		end
		mat_valid <= 1'b1;
		foreach (m[i]) mi[i] <= m[i];
		@(posedge clk);
		while (mat_stall) @(posedge clk);
		quat_expected.push_back(predict_quat(m));
		n_sent++;
	endtask

	task automatic drain_results();
		mat_valid <= 1'b0;
		while (quat_expected.size() != 0) @(posedge clk);
	endtask

	// half near-rotation: axis rotations, sign flips, small perturbations; rest random
	function automatic void rand_matrix(ref elem_t m [9]);
		int kind;
		longint c, s;
		int ax, sg;
		kind = $urandom_range(9);
		if (kind < 3) begin
			foreach (m[i]) m[i] = elem_t'($urandom);
		end else if (kind < 5) begin
			foreach (m[i]) m[i] = elem_t'($urandom_range(2 * 16384) - 16384);
		end else begin
			c = longint'($urandom_range(2 * 16384)) - 16384;
			s = floor_root(16384 * 16384 - c * c);
			if ($urandom_range(1)) s = -s;
			foreach (m[i]) m[i] = '0;
			ax = $urandom_range(2);
			sg = $urandom_range(1) ? -1 : 1;
			case (ax)
				0: begin
					m[0] = elem_t'(sg * ONE); m[4] = elem_t'(c); m[5] = elem_t'(-s);
					m[7] = elem_t'(s); m[8] = elem_t'(c);
				end
				1: begin
					m[4] = elem_t'(sg * ONE); m[0] = elem_t'(c); m[2] = elem_t'(s);
					m[6] = elem_t'(-s); m[8] = elem_t'(c);
				end
				default: begin
					m[8] = elem_t'(sg * ONE); m[0] = elem_t'(c); m[1] = elem_t'(-s);
					m[3] = elem_t'(s); m[4] = elem_t'(c);
				end
			endcase
			foreach (m[i])
				if ($urandom_range(7) == 0) m[i] = m[i] + elem_t'($urandom_range(64) - 32);
		end
	endfunction

	// receiver: stalls per mode, long hold-off on request
	always @(posedge clk) begin
		if (hold_long)
			quat_stall <= 1'b1;
		else if (mode == 2)
			quat_stall <= ($urandom_range(99) < 82);
		else if (mode == 3)
			quat_stall <= ($urandom_range(99) < 17);
		else
			quat_stall <= 1'b0;
	end

	// result checker
	always @(posedge clk) begin
		quat_t e;
		if (arst_n && quat_valid && !quat_stall) begin
			n_recv++;
			if (quat_expected.size() == 0) begin
				$error("quaternion word with no expectation");
				errors++;
			end else begin
				e = quat_expected.pop_front();
				if (degenerate) n_degen++;
				if (quat_w !== e.w) begin
					$error("quat_w exp %0d got %0d", e.w, quat_w); errors++;
				end
				if (quat_x !== e.x) begin
					$error("quat_x exp %0d got %0d", e.x, quat_x); errors++;
				end
				if (quat_y !== e.y) begin
					$error("quat_y exp %0d got %0d", e.y, quat_y); errors++;
				end
				if (quat_z !== e.z) begin
					$error("quat_z exp %0d got %0d", e.z, quat_z); errors++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate exp %0d got %0d", e.degen, degenerate); errors++;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	initial begin
		wait (n_sent >= 200);
		hold_long = 1'b1;
		repeat (150) @(posedge clk);
		hold_long = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rotation_matrix_to_quaternion_top verification failed");
			$finish;
		end
	end

	mat_row_t dir_tbl [$];

	function automatic mat_row_t mk(elem_t a0, a1, a2, a3, a4, a5, a6, a7, a8,
			logic known = 0, elem_t w = 0, x = 0, y = 0, z = 0, logic dg = 0);
		mat_row_t r;
		r.m[0] = a0; r.m[1] = a1; r.m[2] = a2; r.m[3] = a3; r.m[4] = a4;
		r.m[5] = a5; r.m[6] = a6; r.m[7] = a7; r.m[8] = a8;
		r.known = known;
		r.q.w = w; r.q.x = x; r.q.y = y; r.q.z = z; r.q.degen = dg;
		return r;
	endfunction

	initial begin
		elem_t m [9];
		quat_t p;
		// identity and half-turns about each axis
		dir_tbl.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1, ONE, 0, 0, 0, 0));
		dir_tbl.push_back(mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 1, 0, ONE, 0, 0, 0));
		dir_tbl.push_back(mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE, 1, 0, 0, ONE, 0, 0));
		dir_tbl.push_back(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 1, 0, 0, 0, ONE, 0));
		// zero matrix: z path, radicand one
		dir_tbl.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// diagonal extremes, ties: z path or, for a positive trace, w path; large radicand
		dir_tbl.push_back(mk(SMINV, 0, 0, 0, SMINV, 0, 0, 0, SMAXV));
		dir_tbl.push_back(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
		dir_tbl.push_back(mk(SMINV, SMINV, SMINV, SMINV, SMINV, SMINV, SMINV, SMINV, SMINV));
		dir_tbl.push_back(mk(SMAXV, SMAXV, SMAXV, SMAXV, SMAXV, SMAXV, SMAXV, SMAXV, SMAXV));
		dir_tbl.push_back(mk(SMAXV, SMINV, SMAXV, SMINV, SMAXV, SMINV, SMAXV, SMINV, SMAXV));
		// tiny trace: root near one, off-diagonal parts saturate
		dir_tbl.push_back(mk(1, SMINV, SMAXV, SMAXV, 0, SMINV, SMINV, SMAXV, 0));
		// diagonal ties: go to later path
		dir_tbl.push_back(mk(-100, 5, 7, 9, -100, 11, 13, 15, -300));
		dir_tbl.push_back(mk(-100, 5, 7, 9, -300, 11, 13, 15, -100));
		dir_tbl.push_back(mk(-300, 5, 7, 9, -100, 11, 13, 15, -100));
		dir_tbl.push_back(mk(-50, 3, -3, 3, -50, -3, 3, -3, -50));
		// 90 degrees about each axis, then an alternating bit pattern
		dir_tbl.push_back(mk(ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0));
		dir_tbl.push_back(mk(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0));
		dir_tbl.push_back(mk(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE));
		dir_tbl.push_back(mk(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
			16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[k]) begin
			if (dir_tbl[k].known) begin
				p = predict_quat(dir_tbl[k].m);
				if (p != dir_tbl[k].q) begin
					$error("predictor disagrees with table row %0d", k);
					errors++;
				end
			end
			send_matrix(dir_tbl[k].m);
		end
		drain_results();

		// random phases; sender pause until drained between phases
		for (int ph = 0; ph < 4; ph++) begin
			mode = ph;
			for (int k = 0; k < N_RAND / 4; k++) begin
				rand_matrix(m);
				send_matrix(m);
			end
			drain_results();
		end
		mode = 0;
		repeat (LAT + 10) @(posedge clk);

		$display("sent %0d matrices, checked %0d quaternions (%0d degenerate)",
			n_sent, n_recv, n_degen);
		if (errors == 0 && quat_expected.size() == 0)
			$display("rotation_matrix_to_quaternion_top verification clean");
		else
			$display("rotation_matrix_to_quaternion_top verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/rmq_pkg.sv
design/rmq_front.sv
design/rotation_matrix_to_quaternion_top.sv
design/rmq_checker.sv
bench/rotation_matrix_to_quaternion_top_tb.sv
